@@ rtl/wcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Wall column span setup package
// Shared types, stage layout and register indexes for the span setup pipeline.
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int unsigned DIV1_STAGES = 15;
    localparam int unsigned DIV2_STAGES = 26;
    localparam int unsigned ST_IN       = 0;
    localparam int unsigned ST_LH       = ST_IN + DIV1_STAGES + 1;
    localparam int unsigned ST_MUL      = ST_LH + DIV2_STAGES + 1;
    localparam int unsigned ST_OUT      = ST_MUL + 1;
    localparam int unsigned NSTG        = ST_OUT + 1;

    localparam logic        REG_VIEW_DIST    = 1'b0;
    localparam logic        REG_PLANE_HEIGHT = 1'b1;

    localparam logic [19:0] VIEW_DIST_RST    = 20'd141824;
    localparam logic [11:0] PLANE_HEIGHT_RST = 12'd240;
    localparam logic [15:0] LH_MAX           = 16'hFFFE;
    localparam logic [24:0] ROW_START_MAX    = 25'h1FFFFFF;
    localparam logic [9:0]  DRAW_END_MAX     = 10'h3FF;

    typedef struct packed {
        logic [10:0] sx;
        logic [7:0]  tid;
        logic [9:0]  col;
        logic [9:0]  hm;
        logic [29:0] rem1;
        logic [24:0] den1;
        logic [15:0] q1;
        logic        sat;
        logic [15:0] lh;
        logic        empty;
        logic [25:0] rem2;
        logic [15:0] den2;
        logic [25:0] step;
        logic [41:0] prod;
        logic [10:0] dstart;
        logic [9:0]  dend;
    } t_stage;

endpackage

@@ rtl/wall_column_span_setup.sv @@
// ----------------------------------------------------------------------------
// Wall column span setup
// Accepts one column per cycle while the output is not stalled.
// Two restoring dividers retire one quotient bit per stage, then one multiply stage.
// The whole pipeline stalls together while a finished result waits on the output.
// Reset is synchronous, active low; it empties the pipeline and restores the registers.
// ----------------------------------------------------------------------------
module wall_column_span_setup (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // screen_x, perp_dist, tex_u, texture_id, tex_width_m, tex_height_m, pad.
    input  logic [79:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x, out_texture, line_height, draw_start, draw_end, tex_col,
    // row_start, row_step, pad.
    output logic [119:0] o_m_axis_tdata,
    // empty_res.
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [19:0]  i_cfg_data
);

    localparam int unsigned NS = wcs_pkg::NSTG;

    logic [19:0]      r_view;
    logic [11:0]      r_plane;
    logic [NS-1:0]    r_vld;
    wcs_pkg::t_stage  r_st [NS];
    wcs_pkg::t_stage  n_st [NS];
    logic             w_adv;
    logic [11:0]      w_ph;
    logic [10:0]      w_half;

    assign w_adv           = !r_vld[NS-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;
    assign w_ph            = r_plane & 12'hFFE;
    assign w_half          = w_ph[11:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view  <= wcs_pkg::VIEW_DIST_RST;
            r_plane <= wcs_pkg::PLANE_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wcs_pkg::REG_VIEW_DIST:    r_view  <= i_cfg_data;
                wcs_pkg::REG_PLANE_HEIGHT: r_plane <= i_cfg_data[11:0];
                default:                   r_view  <= r_view;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NS; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_comb begin
        logic [25:0] prod_col;
        logic [23:0] pd;
        prod_col          = 26'(i_s_axis_tdata[68:59]) * 26'(i_s_axis_tdata[50:35]);
        pd                = i_s_axis_tdata[34:11];
        n_st[0]           = '0;
        n_st[0].sx        = i_s_axis_tdata[10:0];
        n_st[0].tid       = i_s_axis_tdata[58:51];
        n_st[0].col       = prod_col[25:16];
        n_st[0].hm        = i_s_axis_tdata[78:69];
        n_st[0].rem1      = {1'b0, r_view, 9'b0} + {6'b0, pd};
        n_st[0].den1      = {pd, 1'b0};
        n_st[0].sat       = ({11'b0, n_st[0].rem1} >= {n_st[0].den1, 16'b0});
    end

    for (genvar s = 1; s <= int'(wcs_pkg::DIV1_STAGES); s++) begin : g_div1
        always_comb begin
            logic [40:0] dsh;
            dsh     = 41'(r_st[s-1].den1) << (16 - s);
            n_st[s] = r_st[s-1];
            if ({11'b0, r_st[s-1].rem1} >= dsh) begin
                n_st[s].rem1      = 30'({11'b0, r_st[s-1].rem1} - dsh);
                n_st[s].q1[16-s]  = 1'b1;
            end
        end
    end

    always_comb begin
        logic [15:0] lh;
        lh = r_st[wcs_pkg::ST_LH-1].sat ? wcs_pkg::LH_MAX
                                         : {r_st[wcs_pkg::ST_LH-1].q1[15:1], 1'b0};
        n_st[wcs_pkg::ST_LH]       = r_st[wcs_pkg::ST_LH-1];
        n_st[wcs_pkg::ST_LH].lh    = lh;
        n_st[wcs_pkg::ST_LH].empty = (lh == 16'd0);
        n_st[wcs_pkg::ST_LH].den2  = lh - 16'd1;
        n_st[wcs_pkg::ST_LH].rem2  = {r_st[wcs_pkg::ST_LH-1].hm, 16'b0};
        n_st[wcs_pkg::ST_LH].step  = '0;
    end

    for (genvar s = wcs_pkg::ST_LH + 1; s < int'(wcs_pkg::ST_MUL); s++) begin : g_div2
        always_comb begin
            logic [41:0] dsh;
            dsh     = 42'(r_st[s-1].den2) << (int'(wcs_pkg::ST_MUL) - 1 - s);
            n_st[s] = r_st[s-1];
            if ({16'b0, r_st[s-1].rem2} >= dsh) begin
                n_st[s].rem2 = 26'({16'b0, r_st[s-1].rem2} - dsh);
                n_st[s].step[int'(wcs_pkg::ST_MUL) - 1 - s] = 1'b1;
            end
        end
    end

    always_comb begin
        wcs_pkg::t_stage p;
        logic [15:0] hidden;
        logic [11:0] vis;
        logic [11:0] sum;
        p      = r_st[wcs_pkg::ST_MUL-1];
        hidden = (p.lh > 16'(w_ph)) ? 16'((p.lh - 16'(w_ph)) >> 1) : 16'd0;
        vis    = (p.lh > 16'(w_ph)) ? w_ph : p.lh[11:0];
        sum    = 12'(w_half) + 12'(vis[11:1]);
        n_st[wcs_pkg::ST_MUL]        = p;
        n_st[wcs_pkg::ST_MUL].step   = p.empty ? 26'd0 : p.step;
        n_st[wcs_pkg::ST_MUL].prod   = p.empty ? 42'd0 : 42'(p.step) * 42'(hidden);
        n_st[wcs_pkg::ST_MUL].dstart = w_half - 11'(vis[11:1]);
        if (sum == 12'd0) begin
            n_st[wcs_pkg::ST_MUL].dend = 10'd0;
        end else if (sum > 12'd1024) begin
            n_st[wcs_pkg::ST_MUL].dend = wcs_pkg::DRAW_END_MAX;
        end else begin
            n_st[wcs_pkg::ST_MUL].dend = 10'(sum - 12'd1);
        end
    end

    always_comb begin
        n_st[wcs_pkg::ST_OUT] = r_st[wcs_pkg::ST_OUT-1];
        if (r_st[wcs_pkg::ST_OUT-1].prod > 42'(wcs_pkg::ROW_START_MAX)) begin
            n_st[wcs_pkg::ST_OUT].prod = 42'(wcs_pkg::ROW_START_MAX);
        end
    end

    assign o_m_axis_tvalid = r_vld[NS-1];
    assign o_m_axis_tuser  = r_st[NS-1].empty;
    assign o_m_axis_tdata  = {3'b0,
                              r_st[NS-1].step,
                              r_st[NS-1].prod[24:0],
                              r_st[NS-1].col,
                              r_st[NS-1].dend,
                              r_st[NS-1].dstart,
                              r_st[NS-1].lh,
                              r_st[NS-1].tid,
                              r_st[NS-1].sx};

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (o_m_axis_tdata[34:19] == 16'd0 && o_m_axis_tdata[116:91] == 26'd0
         && o_m_axis_tdata[90:66] == 25'd0))
        else $error("empty span carries nonzero height or step");

    a_lh_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[19] == 1'b0))
        else $error("line height is odd");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule
